// ----- sv/lmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED notification mode controller package
// Shared widths, request and command codes, palette and queue word types.
// ----------------------------------------------------------------------------
package lmc_pkg;

    localparam int CMD_W   = 3;
    localparam int COLOR_W = 24;
    localparam int ACT_W   = 3;
    localparam int VAL_W   = 8;
    localparam int SKIP_W  = 2;
    localparam int MODE_W  = 2;
    localparam int CNT_W   = 2;
    localparam int DIST_W  = 10;
    localparam int LUMA_W  = 16;
    localparam int NUM_PAL = 7;
    localparam int IDX_W   = 3;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [CMD_W-1:0] CMD_BACKLIGHT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BUTTONS   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_NOTIFY    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ATTENTION = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BATTERY   = 3'd4;

    localparam logic [ACT_W-1:0] ACT_BRIGHT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RESET   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MODE    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LOWER   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RED_DIM = 3'd4;
    localparam logic [ACT_W-1:0] ACT_BTN_ON  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_BTN_OFF = 3'd6;

    localparam logic [MODE_W-1:0] MODE_NONE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NOTIFY    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ATTENTION = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BATTERY   = 2'd3;

    localparam logic [CNT_W-1:0]  CNT_MAX       = 2'd3;
    localparam logic [SKIP_W-1:0] SKIP_RESET    = 2'd2;
    localparam logic [VAL_W-1:0]  CH_BTN_A      = 8'd5;
    localparam logic [VAL_W-1:0]  CH_BTN_B      = 8'd6;
    localparam logic [IDX_W-1:0]  IDX_RED       = 3'd1;
    localparam logic [DIST_W-1:0] DIST_INIT     = 10'd765;
    localparam logic [LUMA_W-1:0] LUMA_KR       = 16'd77;
    localparam logic [LUMA_W-1:0] LUMA_KG       = 16'd150;
    localparam logic [LUMA_W-1:0] LUMA_KB       = 16'd29;

    localparam logic [7:0] PAL_R [NUM_PAL] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd160, 8'd0, 8'd255};
    localparam logic [7:0] PAL_G [NUM_PAL] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd32, 8'd255, 8'd255};
    localparam logic [7:0] PAL_B [NUM_PAL] = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd240, 8'd255, 8'd255};

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [VAL_W-1:0] value;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t res0;
        result_t res1;
    } entry_t;

    function automatic logic [DIST_W-1:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        logic [DIST_W-1:0] d;
        begin
            if (a > b)
            begin
                d = {2'b00, a} - {2'b00, b};
            end
            else
            begin
                d = {2'b00, b} - {2'b00, a};
            end
            return d;
        end
    endfunction

endpackage

// ----- sv/lmc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED controller front end
// Computes luma and palette distances, then classifies each request,
// updates pattern mode and attention count, and queues its commands.
// ----------------------------------------------------------------------------
module lmc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lmc_pkg::CMD_W-1:0]    in_cmd,
    input  logic [lmc_pkg::COLOR_W-1:0]  in_color,
    input  logic [lmc_pkg::SKIP_W-1:0]   attention_skip,
    input  logic                         q_full,
    output logic                         push,
    output lmc_pkg::entry_t              push_data
);
    import lmc_pkg::*;

    logic [7:0]        red, green, blue;
    logic [LUMA_W-1:0] luma_full;
    logic [DIST_W-1:0] dist_next [NUM_PAL];

    logic              s1_valid_reg, s1_valid_next;
    logic [CMD_W-1:0]  s1_cmd_reg, s1_cmd_next;
    logic              s1_on_reg, s1_on_next;
    logic [VAL_W-1:0]  s1_luma_reg, s1_luma_next;
    logic [DIST_W-1:0] s1_dist_reg [NUM_PAL];

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [CNT_W-1:0]  att_cnt_reg, att_cnt_next;

    logic              advance;
    logic [DIST_W-1:0] best;
    logic [IDX_W-1:0]  best_idx;
    logic [CNT_W-1:0]  att_cnt_inc;
    logic [1:0]        n_res;
    result_t           main_res;
    entry_t            entry;

    assign red   = in_color[23:16];
    assign green = in_color[15:8];
    assign blue  = in_color[7:0];

    always_comb
    begin
        luma_full = LUMA_KR * {8'd0, red} + LUMA_KG * {8'd0, green} + LUMA_KB * {8'd0, blue};
        for (int i = 0; i < NUM_PAL; i++)
        begin
            dist_next[i] = absdiff8(red, PAL_R[i]) + absdiff8(green, PAL_G[i])
                         + absdiff8(blue, PAL_B[i]);
        end
    end

    assign advance  = s1_valid_reg && !q_full;
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = in_ready ? in_valid : s1_valid_reg;
        s1_cmd_next   = in_cmd;
        s1_on_next    = (in_color != '0);
        s1_luma_next  = luma_full[LUMA_W-1:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg  <= s1_cmd_next;
            s1_on_reg   <= s1_on_next;
            s1_luma_reg <= s1_luma_next;
            for (int i = 0; i < NUM_PAL; i++)
            begin
                s1_dist_reg[i] <= dist_next[i];
            end
        end
    end

    // Strictly smaller distance wins, so the first of equal candidates is kept.
    always_comb
    begin
        best     = DIST_INIT;
        best_idx = '0;
        for (int i = 0; i < NUM_PAL; i++)
        begin
            if (s1_dist_reg[i] < best)
            begin
                best     = s1_dist_reg[i];
                best_idx = IDX_W'(i);
            end
        end
        best_idx = best_idx + IDX_W'(1);
    end

    assign att_cnt_inc = (att_cnt_reg == CNT_MAX) ? att_cnt_reg : att_cnt_reg + CNT_W'(1);

    always_comb
    begin
        n_res        = 2'd0;
        entry        = '0;
        main_res     = '0;
        mode_next    = mode_reg;
        att_cnt_next = att_cnt_reg;
        case (s1_cmd_reg)
            CMD_BACKLIGHT:
            begin
                entry.res0 = '{action: ACT_BRIGHT, value: s1_luma_reg};
                entry.res1 = '{action: ACT_RESET, value: '0};
                if (!s1_on_reg && mode_reg == MODE_ATTENTION)
                begin
                    n_res     = 2'd2;
                    mode_next = MODE_NONE;
                end
                else
                begin
                    n_res = 2'd1;
                end
            end
            CMD_BUTTONS:
            begin
                n_res = 2'd2;
                entry.res0.action = s1_on_reg ? ACT_BTN_ON : ACT_BTN_OFF;
                entry.res0.value  = CH_BTN_A;
                entry.res1.action = s1_on_reg ? ACT_BTN_ON : ACT_BTN_OFF;
                entry.res1.value  = CH_BTN_B;
            end
            CMD_NOTIFY, CMD_ATTENTION, CMD_BATTERY:
            begin
                if (s1_cmd_reg == CMD_ATTENTION)
                begin
                    att_cnt_next = att_cnt_inc;
                end
                if (s1_cmd_reg == CMD_ATTENTION && s1_on_reg
                    && {1'b0, att_cnt_inc} <= {1'b0, attention_skip})
                begin
                    n_res = 2'd0;
                end
                else
                begin
                    if (s1_cmd_reg == CMD_ATTENTION)
                    begin
                        main_res  = '{action: ACT_LOWER, value: '0};
                        mode_next = s1_on_reg ? MODE_ATTENTION : MODE_NONE;
                    end
                    else if (s1_cmd_reg == CMD_BATTERY && best_idx == IDX_RED)
                    begin
                        main_res  = '{action: ACT_RED_DIM, value: '0};
                        mode_next = s1_on_reg ? MODE_BATTERY : MODE_NONE;
                    end
                    else
                    begin
                        main_res  = '{action: ACT_MODE, value: {5'd0, best_idx}};
                        if (s1_cmd_reg == CMD_NOTIFY)
                        begin
                            mode_next = s1_on_reg ? MODE_NOTIFY : MODE_NONE;
                        end
                        else
                        begin
                            mode_next = s1_on_reg ? MODE_BATTERY : MODE_NONE;
                        end
                    end
                    if (mode_reg != MODE_NONE)
                    begin
                        entry.res0 = '{action: ACT_RESET, value: '0};
                        entry.res1 = main_res;
                        n_res      = s1_on_reg ? 2'd2 : 2'd1;
                    end
                    else
                    begin
                        entry.res0 = main_res;
                        n_res      = s1_on_reg ? 2'd1 : 2'd0;
                    end
                end
            end
            default:
            begin
                n_res = 2'd0;
            end
        endcase
        entry.two = (n_res == 2'd2);
    end

    assign push      = advance && (n_res != 2'd0);
    assign push_data = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NONE;
            att_cnt_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            att_cnt_reg <= att_cnt_next;
        end
    end

endmodule

// ----- sv/lmc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED controller command queue
// Small FIFO of per-request command words between front and back end.
// ----------------------------------------------------------------------------
module lmc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lmc_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output lmc_pkg::entry_t pop_data,
    output logic            empty
);
    import lmc_pkg::*;

    entry_t            mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/lmc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED controller back end
// Unpacks queued command words into single result words on the output.
// ----------------------------------------------------------------------------
module lmc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  lmc_pkg::entry_t            pop_data,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [lmc_pkg::ACT_W-1:0]  out_action,
    output logic [lmc_pkg::VAL_W-1:0]  out_value,
    output logic                       out_last
);
    import lmc_pkg::*;

    logic    idx_reg, idx_next;
    logic    valid_reg, valid_next;
    result_t res_reg, res_next;
    logic    last_reg, last_next;
    logic    load, is_last;

    assign load    = (!valid_reg || out_ready) && !q_empty;
    assign is_last = !pop_data.two || idx_reg;
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        res_next   = idx_reg ? pop_data.res1 : pop_data.res0;
        last_next  = is_last;
        if (load)
        begin
            idx_next   = !is_last;
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= res_next;
            last_reg <= last_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_action = res_reg.action;
    assign out_value  = res_reg.value;
    assign out_last   = last_reg;

endmodule

// ----- sv/led_notification_mode_controller_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED notification mode controller
// Turns light requests into LED driver commands, up to two per request.
// A request passes the front-end register, the queue and the output register.
// Throughput: one request per cycle enters while the queue is not full; the output
// stage delivers one result word per cycle while the output is ready.
// Reset clears pattern mode, attention count and all valid state; the skip
// register resets to two.
// ----------------------------------------------------------------------------
module led_notification_mode_controller_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lmc_pkg::COLOR_W-1:0]   s_axis_tdata,   // color
    input  logic [lmc_pkg::CMD_W-1:0]     s_axis_tuser,   // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lmc_pkg::VAL_W-1:0]     m_axis_tdata,   // value
    output logic [lmc_pkg::ACT_W-1:0]     m_axis_tuser,   // action
    output logic                          m_axis_tlast,
    input  logic                          cfg_we,
    input  logic [lmc_pkg::SKIP_W-1:0]    cfg_wdata
);
    import lmc_pkg::*;

    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic              push, pop, q_full, q_empty;
    entry_t            push_data, pop_data;

    assign skip_next = cfg_we ? cfg_wdata : skip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= SKIP_RESET;
        end
        else
        begin
            skip_reg <= skip_next;
        end
    end

    lmc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_cmd         (s_axis_tuser),
        .in_color       (s_axis_tdata),
        .attention_skip (skip_reg),
        .q_full         (q_full),
        .push           (push),
        .push_data      (push_data)
    );

    lmc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    lmc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_action (m_axis_tuser),
        .out_value  (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule
